[rtl/fnd_pkg.sv]
// Shared types and constants for the floppy nibble drive.
// Depends on nothing; the interfaces, top, control and shift stages use it by scoped names.
`default_nettype none

package fnd_pkg;

	// Field widths of the item channels and the configuration port
	localparam int CMD_W   = 3;
	localparam int SWA_W   = 4;
	localparam int VAL_W   = 8;
	localparam int ITRK_W  = 6;
	localparam int IOFS_W  = 13;
	localparam int HT_W    = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	// Item commands
	typedef enum logic [CMD_W-1:0] {
		CMD_SWITCH_READ    = 3'd0,
		CMD_SWITCH_WRITE   = 3'd1,
		CMD_SHIFT_READ     = 3'd2,
		CMD_MOTOR_SET      = 3'd3,
		CMD_SET_HALF_TRACK = 3'd4,
		CMD_LOAD_BYTE      = 3'd5
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRACK_LENGTH    = 1'b0,
		REG_WRITE_PROTECTED = 1'b1
	} cfg_reg_t;

	// Latch soft switches
	localparam logic [SWA_W-1:0] SW_Q6L = 4'hC;
	localparam logic [SWA_W-1:0] SW_Q6H = 4'hD;
	localparam logic [SWA_W-1:0] SW_Q7L = 4'hE;
	localparam logic [SWA_W-1:0] SW_Q7H = 4'hF;

	// What the shift stage does with an item
	typedef enum logic [1:0] {
		SH_NONE,   // pass the read data computed up front
		SH_HOLD,   // motor off: show shifter high byte, no change
		SH_SHIFT,  // shift once
		SH_LOAD    // load track byte, pre-shift, shift once
	} shift_op_t;

	// Item in flight between the control stage and the shift stage
	typedef struct packed {
		logic            valid;
		shift_op_t       op;
		logic [VAL_W-1:0] read_data;
		logic [HT_W-1:0] half_track;
		logic            modified;
		logic            motor_on;
	} item_t;

endpackage

`default_nettype wire

[rtl/fnd_in_if.sv]
// Input item channel of the floppy nibble drive.
// Depends on fnd_pkg for field widths.
`default_nettype none

interface fnd_in_if;
	logic                          valid;
	logic                          ready;
	logic [fnd_pkg::CMD_W-1:0]     command;
	logic [fnd_pkg::SWA_W-1:0]     switch_address;
	logic [fnd_pkg::VAL_W-1:0]     value;
	logic [fnd_pkg::ITRK_W-1:0]    image_track;
	logic [fnd_pkg::IOFS_W-1:0]    image_offset;

	modport source (output valid, command, switch_address, value, image_track,
		image_offset, input ready);
	modport sink (input valid, command, switch_address, value, image_track,
		image_offset, output ready);
endinterface

`default_nettype wire

[rtl/fnd_out_if.sv]
// Result item channel of the floppy nibble drive.
// Depends on fnd_pkg for field widths.
`default_nettype none

interface fnd_out_if;
	logic                       valid;
	logic                       ready;
	logic [fnd_pkg::VAL_W-1:0]  read_data;
	logic [fnd_pkg::HT_W-1:0]   half_track;
	logic                       modified;
	logic                       motor_on;

	modport source (output valid, read_data, half_track, modified, motor_on,
		input ready);
	modport sink (input valid, read_data, half_track, modified, motor_on,
		output ready);
endinterface

`default_nettype wire

[rtl/floppy_nibble_drive_top.sv]
// Floppy nibble drive: an accepted item passes the stage register item_s1, then the result register.
// Throughput one item per cycle while results are taken; the single-port track memory serves at most one
// access per item, a read for a shift-read load or a write for a commit/load.
// A result waits in the output register while the next item is taken.
// Reset clears head, latch, motor and config state at once; the track memory
// is not cleared and reads undefined until written.
`default_nettype none

module floppy_nibble_drive_top #(
	parameter int TRACK_COUNT     = 35,
	parameter int TRACK_BYTES     = 6656,
	parameter int LAST_HALF_TRACK = 68
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [fnd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fnd_pkg::CFG_DATA_W-1:0]  cfg_data,
	fnd_in_if.sink                               in_ch,
	fnd_out_if.source                            out_ch
);

	localparam int DEPTH  = TRACK_COUNT * TRACK_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);

	fnd_pkg::item_t    item_s1;
	logic              adv;
	logic              mem_en, mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [7:0]        mem_wdata, mem_rdata;

	fnd_ctrl #(
		.TRACK_COUNT     (TRACK_COUNT),
		.TRACK_BYTES     (TRACK_BYTES),
		.LAST_HALF_TRACK (LAST_HALF_TRACK),
		.ADDR_W          (ADDR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.adv       (adv),
		.item_s1   (item_s1),
		.mem_en    (mem_en),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata)
	);

	fnd_track_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	fnd_shift u_shift (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.rdata   (mem_rdata),
		.adv     (adv),
		.out_ch  (out_ch)
	);

endmodule

`default_nettype wire

[rtl/fnd_track_mem.sv]
// Single-port track byte store with registered read data.
// Depends on nothing; contents are undefined until written.
`default_nettype none

module fnd_track_mem #(
	parameter int DEPTH  = 232960,
	parameter int ADDR_W = 18
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [7:0]        wdata,
	output logic [7:0]             rdata
);

	logic [7:0] mem [DEPTH];

	// Write or read one byte per enabled cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

[rtl/fnd_ctrl.sv]
// Control stage: head, latch, motor and config state, track memory requests.
// Depends on fnd_pkg and fnd_in_if; feeds the shift stage through item_s1.
`default_nettype none

module fnd_ctrl #(
	parameter int TRACK_COUNT     = 35,
	parameter int TRACK_BYTES     = 6656,
	parameter int LAST_HALF_TRACK = 68,
	parameter int ADDR_W          = 18
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [fnd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fnd_pkg::CFG_DATA_W-1:0]    cfg_data,
	fnd_in_if.sink                                 in_ch,
	input  wire logic                              adv,
	output fnd_pkg::item_t                         item_s1,
	output logic                                   mem_en,
	output logic                                   mem_we,
	output logic [ADDR_W-1:0]                      mem_addr,
	output logic [7:0]                             mem_wdata
);

	localparam int OFS_W = $clog2(TRACK_BYTES);
	localparam int LEN_W = $clog2(TRACK_BYTES + 1);
	localparam logic [ADDR_W-1:0] TB_A = ADDR_W'(TRACK_BYTES);
	localparam logic [fnd_pkg::HT_W-1:0] LAST_HT = fnd_pkg::HT_W'(LAST_HALF_TRACK);

	logic [LEN_W-1:0]            eff_len_q;
	logic                        wp_q;
	logic [fnd_pkg::HT_W-1:0]    head_track_q, n_head;
	logic [OFS_W-1:0]            head_offset_q, n_off;
	logic [3:0]                  bits_left_q, n_bits;
	logic [7:0]                  write_latch_q, n_wl;
	logic                        q6_q, n_q6;
	logic                        q7_q, n_q7;
	logic                        motor_q, n_motor;
	logic                        dirty_q, n_dirty;

	logic                        accept;
	logic [OFS_W-1:0]            off_w, off_adv;
	logic [LEN_W-1:0]            off_inc;
	logic [5:0]                  whole;
	logic                        whole_ok, image_ok;
	logic [ADDR_W-1:0]           base;
	logic [1:0]                  cur, phase;
	logic                        req_en, req_we;
	fnd_pkg::shift_op_t          op;
	logic [7:0]                  rd;

	assign in_ch.ready = !item_s1.valid || adv;
	assign accept      = in_ch.valid && in_ch.ready;

	// Head offset wrapped to the track length, and one past it
	always_comb begin
		off_w   = (LEN_W'(head_offset_q) >= eff_len_q) ? '0 : head_offset_q;
		off_inc = LEN_W'(off_w) + LEN_W'(1);
		off_adv = (off_inc >= eff_len_q) ? '0 : OFS_W'(off_inc);
	end

	assign whole    = head_track_q[fnd_pkg::HT_W-1:1];
	assign whole_ok = 32'(whole) < TRACK_COUNT;
	assign base     = ADDR_W'(whole) * TB_A;
	assign image_ok = (32'(in_ch.image_track) < TRACK_COUNT)
		&& (32'(in_ch.image_offset) < TRACK_BYTES);
	assign cur      = head_track_q[1:0];
	assign phase    = in_ch.switch_address[2:1];

	// Decode the item into next state, a memory request and a shift op
	always_comb begin
		n_head    = head_track_q;
		n_off     = head_offset_q;
		n_bits    = bits_left_q;
		n_wl      = write_latch_q;
		n_q6      = q6_q;
		n_q7      = q7_q;
		n_motor   = motor_q;
		n_dirty   = dirty_q;
		req_en    = 1'b0;
		req_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = write_latch_q;
		op        = fnd_pkg::SH_NONE;
		rd        = '0;
		case (in_ch.command)
			fnd_pkg::CMD_SWITCH_READ: begin
				if (!in_ch.switch_address[3] && in_ch.switch_address[0]) begin
					// step toward the energized phase, clamped
					if (cur == phase + 2'd1) begin
						n_head = (head_track_q == '0) ? '0 : head_track_q - 7'd1;
					end else if (cur == phase + 2'd3) begin
						n_head = (head_track_q >= LAST_HT) ? LAST_HT : head_track_q + 7'd1;
					end
				end else begin
					case (in_ch.switch_address)
						fnd_pkg::SW_Q6L: begin
							n_q6 = 1'b0;
							if (q7_q) begin
								// commit the write latch one byte past the head
								n_bits = '0;
								n_off  = off_adv;
								if (whole_ok) begin
									req_en   = 1'b1;
									req_we   = 1'b1;
									mem_addr = base + ADDR_W'(off_adv);
									n_dirty  = 1'b1;
								end
							end
						end
						fnd_pkg::SW_Q6H: n_q6 = 1'b1;
						fnd_pkg::SW_Q7L: begin
							n_q7 = 1'b0;
							rd   = {wp_q & q6_q, 7'b0};
						end
						fnd_pkg::SW_Q7H: n_q7 = 1'b1;
						default: ;
					endcase
				end
			end
			fnd_pkg::CMD_SWITCH_WRITE: begin
				case (in_ch.switch_address)
					fnd_pkg::SW_Q6H: begin
						n_wl = in_ch.value;
						n_q6 = 1'b1;
					end
					fnd_pkg::SW_Q7H: begin
						n_wl = in_ch.value;
						n_q7 = 1'b1;
					end
					default: ;
				endcase
			end
			fnd_pkg::CMD_SHIFT_READ: begin
				if (!motor_q) begin
					op = fnd_pkg::SH_HOLD;
				end else if (bits_left_q == '0 && whole_ok) begin
					// fetch the byte under the head, advance the head
					op       = fnd_pkg::SH_LOAD;
					req_en   = 1'b1;
					mem_addr = base + ADDR_W'(off_w);
					n_off    = off_adv;
					n_bits   = 4'd1;
				end else begin
					op     = fnd_pkg::SH_SHIFT;
					n_bits = bits_left_q - 4'd1;
				end
			end
			fnd_pkg::CMD_MOTOR_SET: n_motor = in_ch.value[0];
			fnd_pkg::CMD_SET_HALF_TRACK: begin
				n_head = (in_ch.value > 8'(LAST_HALF_TRACK)) ? LAST_HT
					: in_ch.value[fnd_pkg::HT_W-1:0];
			end
			fnd_pkg::CMD_LOAD_BYTE: begin
				if (image_ok) begin
					req_en    = 1'b1;
					req_we    = 1'b1;
					mem_addr  = ADDR_W'(in_ch.image_track) * TB_A
						+ ADDR_W'(in_ch.image_offset);
					mem_wdata = in_ch.value;
				end
			end
			default: ;
		endcase
	end

	assign mem_en = accept && req_en;
	assign mem_we = req_we;

	// Hold configuration; clamp track length on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_len_q <= LEN_W'(TRACK_BYTES);
			wp_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				fnd_pkg::REG_TRACK_LENGTH: begin
					if (cfg_data == '0) begin
						eff_len_q <= LEN_W'(1);
					end else if (32'(cfg_data) > TRACK_BYTES) begin
						eff_len_q <= LEN_W'(TRACK_BYTES);
					end else begin
						eff_len_q <= LEN_W'(cfg_data);
					end
				end
				fnd_pkg::REG_WRITE_PROTECTED: wp_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Advance drive state and load the stage register on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_track_q  <= '0;
			head_offset_q <= '0;
			bits_left_q   <= '0;
			write_latch_q <= '0;
			q6_q          <= 1'b0;
			q7_q          <= 1'b0;
			motor_q       <= 1'b0;
			dirty_q       <= 1'b0;
			item_s1       <= '0;
		end else begin
			if (accept) begin
				head_track_q       <= n_head;
				head_offset_q      <= n_off;
				bits_left_q        <= n_bits;
				write_latch_q      <= n_wl;
				q6_q               <= n_q6;
				q7_q               <= n_q7;
				motor_q            <= n_motor;
				dirty_q            <= n_dirty;
				item_s1.valid      <= 1'b1;
				item_s1.op         <= op;
				item_s1.read_data  <= rd;
				item_s1.half_track <= n_head;
				item_s1.modified   <= n_dirty;
				item_s1.motor_on   <= n_motor;
			end else if (adv) begin
				item_s1.valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/fnd_shift.sv]
// Shift stage: 16-bit read shifter fed by track memory data, result register.
// Depends on fnd_pkg and fnd_out_if; takes items from fnd_ctrl.
`default_nettype none

module fnd_shift (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  fnd_pkg::item_t       item_s1,
	input  wire logic [7:0]      rdata,
	output logic                 adv,
	fnd_out_if.source            out_ch
);

	logic [15:0] shifter_q, n_shifter;
	logic [7:0]  n_data;
	logic        out_valid_q;
	logic [7:0]  read_data_q;
	logic [fnd_pkg::HT_W-1:0] half_track_q;
	logic        modified_q;
	logic        motor_on_q;

	// Move the item on when the result register is free or being taken
	assign adv = item_s1.valid && (!out_valid_q || out_ch.ready);

	// Apply the shift op to the shifter
	always_comb begin
		n_shifter = shifter_q;
		n_data    = item_s1.read_data;
		case (item_s1.op)
			fnd_pkg::SH_HOLD: n_data = shifter_q[15:8];
			fnd_pkg::SH_SHIFT: begin
				n_shifter = {shifter_q[14:0], 1'b0};
				n_data    = n_shifter[15:8];
			end
			fnd_pkg::SH_LOAD: begin
				n_shifter = {1'b0, rdata, 7'b0};
				n_data    = n_shifter[15:8];
			end
			default: ;
		endcase
	end

	// Hold shifter and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shifter_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				shifter_q   <= n_shifter;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_q  <= n_data;
			half_track_q <= item_s1.half_track;
			modified_q   <= item_s1.modified;
			motor_on_q   <= item_s1.motor_on;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.read_data  = read_data_q;
	assign out_ch.half_track = half_track_q;
	assign out_ch.modified   = modified_q;
	assign out_ch.motor_on   = motor_on_q;

endmodule

`default_nettype wire

[rtl/fnd_check.sv]
// Port-level checks for the floppy nibble drive, bound to the top level.
// Depends on the top level's port names only.
`default_nettype none

module fnd_check #(
	parameter int LAST_HALF_TRACK = 68
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_read_data,
	input wire logic [6:0] out_half_track,
	input wire logic       out_modified,
	input wire logic       out_motor_on
);

	logic [2:0] pending_q;
	logic       mod_seen_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Track items in flight and whether a written byte was reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			mod_seen_q <= 1'b0;
		end else begin
			pending_q <= pending_q + 3'(in_acc) - 3'(out_acc);
			if (out_acc && out_modified) begin
				mod_seen_q <= 1'b1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_read_data)
			&& $stable(out_half_track) && $stable(out_modified) && $stable(out_motor_on))
		else $error("result item changed while stalled");

	a_half_track_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_half_track) <= LAST_HALF_TRACK)
		else $error("half-track beyond last position");

	a_modified_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mod_seen_q |-> out_modified)
		else $error("modified flag dropped");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result item without an accepted input item");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("more than two items in flight");

endmodule

bind floppy_nibble_drive_top fnd_check #(
	.LAST_HALF_TRACK (LAST_HALF_TRACK)
) u_fnd_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.out_read_data  (out_ch.read_data),
	.out_half_track (out_ch.half_track),
	.out_modified   (out_ch.modified),
	.out_motor_on   (out_ch.motor_on)
);

`default_nettype wire

[verif/floppy_nibble_drive_top_tb.sv]
// Testbench for floppy_nibble_drive_top: drives bus items with bursty pacing, predicts
// each result from its own copy of the drive state, and checks results in order.
// Depends on fnd_pkg, fnd_in_if, fnd_out_if and the top module.
`default_nettype none

module floppy_nibble_drive_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fnd_pkg::*;

	localparam int TRACK_COUNT     = 35;
	localparam int TRACK_BYTES     = 6656;
	localparam int LAST_HALF_TRACK = 68;
	localparam int DISK_BYTES      = TRACK_COUNT * TRACK_BYTES;
	localparam int CLK_PERIOD      = 2;
	localparam int RESET_CYCLES    = 12;
	localparam int IDLE_PAD        = 8;
	localparam int HOLD_CYCLES     = 300;
	localparam int RUN_LIMIT_NS    = 1_000_000;
	localparam int PHASE_ITEMS     = 150;

	// Commands without a defined action and switch offsets by name
	localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
	localparam logic [SWA_W-1:0] SW_IDLE    = 4'h0;
	localparam logic [SWA_W-1:0] SW_PHASE_ON [4] = '{4'h1, 4'h3, 4'h5, 4'h7};

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [SWA_W-1:0]  switch_address;
		logic [VAL_W-1:0]  value;
		logic [ITRK_W-1:0] image_track;
		logic [IOFS_W-1:0] image_offset;
	} bus_op_t;

	typedef struct packed {
		logic [VAL_W-1:0] read_data;
		logic [HT_W-1:0]  half_track;
		logic             modified;
		logic             motor_on;
	} drive_status_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fnd_in_if  in_ch ();
	fnd_out_if out_ch ();

	floppy_nibble_drive_top #(
		.TRACK_COUNT(TRACK_COUNT),
		.TRACK_BYTES(TRACK_BYTES),
		.LAST_HALF_TRACK(LAST_HALF_TRACK)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predicted drive state, starting at reset values
	logic [7:0]        disk_img   [0:DISK_BYTES-1];
	bit                disk_known [0:DISK_BYTES-1];
	logic [HT_W-1:0]   head_ht    = '0;
	logic [IOFS_W-1:0] head_ofs   = '0;
	logic [3:0]        shift_bits = '0;
	logic [15:0]       shifter    = '0;
	logic [7:0]        wr_latch   = '0;
	logic              q6         = 1'b0;
	logic              q7         = 1'b0;
	logic              motor      = 1'b0;
	logic              dirty      = 1'b0;
	logic [12:0]       len_cfg    = 13'(TRACK_BYTES);
	logic              protect_cfg = 1'b0;

	drive_status_t status_q [$];
	int            mismatches = 0;
	int            results_seen = 0;

	// Pacing controls shared between the tests and the two sides
	bit tx_gaps     = 1'b0;
	int tx_burst    = 0;
	bit rx_stalls   = 1'b0;
	bit rx_hold_req = 1'b0;

	function automatic int track_len_eff();
		if (len_cfg == 0) return 1;
		if (len_cfg > TRACK_BYTES) return TRACK_BYTES;
		return int'(len_cfg);
	endfunction

	function automatic logic [IOFS_W-1:0] next_offset(input logic [IOFS_W-1:0] ofs,
			input int lim);
		int nxt;
		nxt = ofs + 1;
		return (nxt >= lim) ? '0 : nxt[IOFS_W-1:0];
	endfunction

	// Advance the predicted drive by one item and return its status
	function automatic drive_status_t drive_step(input bus_op_t op);
		drive_status_t st;
		logic [5:0]    whole;
		int            pos;
		int            lim;
		int unsigned   idx;
		st    = '0;
		whole = head_ht[HT_W-1:1];
		lim   = track_len_eff();
		case (op.command)
			CMD_SWITCH_READ: begin
				pos = head_ht;
				if (!op.switch_address[3] && op.switch_address[0]) begin
					if (head_ht[1:0] == 2'(op.switch_address[2:1] + 2'd1)) pos--;
					else if (head_ht[1:0] == 2'(op.switch_address[2:1] + 2'd3)) pos++;
				end else if (op.switch_address == SW_Q6L) begin
					q6 = 1'b0;
					// commit the latch one byte past the head
					if (q7) begin
						shift_bits = '0;
						if (head_ofs >= lim) head_ofs = '0;
						head_ofs = next_offset(head_ofs, lim);
						if (whole < TRACK_COUNT) begin
							idx = whole * TRACK_BYTES + head_ofs;
							disk_img[idx]   = wr_latch;
							disk_known[idx] = 1'b1;
							dirty = 1'b1;
						end
					end
				end else if (op.switch_address == SW_Q6H) begin
					q6 = 1'b1;
				end else if (op.switch_address == SW_Q7L) begin
					q7 = 1'b0;
					if (q6) st.read_data = {protect_cfg, 7'd0};
				end else if (op.switch_address == SW_Q7H) begin
					q7 = 1'b1;
				end
				if (pos < 0) pos = 0;
				if (pos > LAST_HALF_TRACK) pos = LAST_HALF_TRACK;
				head_ht = pos[HT_W-1:0];
			end
			CMD_SWITCH_WRITE: begin
				if (op.switch_address == SW_Q6H) begin
					wr_latch = op.value;
					q6 = 1'b1;
				end else if (op.switch_address == SW_Q7H) begin
					wr_latch = op.value;
					q7 = 1'b1;
				end
			end
			CMD_SHIFT_READ: begin
				if (motor) begin
					// reload from the track once the shifter runs dry
					if (shift_bits == 0 && whole < TRACK_COUNT) begin
						if (head_ofs >= lim) head_ofs = '0;
						idx = whole * TRACK_BYTES + head_ofs;
						shifter = {8'd0, disk_img[idx]} << 6;
						head_ofs = next_offset(head_ofs, lim);
						shift_bits = 4'd2;
					end
					shifter = shifter << 1;
					shift_bits = shift_bits - 4'd1;
				end
				st.read_data = shifter[15:8];
			end
			CMD_MOTOR_SET: motor = op.value[0];
			CMD_SET_HALF_TRACK: begin
				head_ht = (op.value > LAST_HALF_TRACK) ? HT_W'(LAST_HALF_TRACK)
					: op.value[HT_W-1:0];
			end
			CMD_LOAD_BYTE: begin
				if (op.image_track < TRACK_COUNT && op.image_offset < TRACK_BYTES) begin
					idx = op.image_track * TRACK_BYTES + op.image_offset;
					disk_img[idx]   = op.value;
					disk_known[idx] = 1'b1;
				end
			end
			default: ;
		endcase
		st.half_track = head_ht;
		st.modified   = dirty;
		st.motor_on   = motor;
		return st;
	endfunction

	function automatic bus_op_t mk_op(input logic [CMD_W-1:0] cmd,
			input logic [SWA_W-1:0] addr, input logic [VAL_W-1:0] val,
			input logic [ITRK_W-1:0] trk, input logic [IOFS_W-1:0] ofs);
		bus_op_t op;
		op.command        = cmd;
		op.switch_address = addr;
		op.value          = val;
		op.image_track    = trk;
		op.image_offset   = ofs;
		return op;
	endfunction

	function automatic bus_op_t rand_op(input logic [CMD_W-1:0] cmd);
		return mk_op(cmd, 4'($urandom), 8'($urandom), 6'($urandom), 13'($urandom));
	endfunction

	// Offer one item, hold it until taken, then record its predicted status
	task automatic push_item(input bus_op_t op);
		int gap;
		@(negedge clk);
		if (tx_gaps && tx_burst == 0) begin
			in_ch.valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
			tx_burst = $urandom_range(1, 12);
		end
		in_ch.valid          <= 1'b1;
		in_ch.command        <= op.command;
		in_ch.switch_address <= op.switch_address;
		in_ch.value          <= op.value;
		in_ch.image_track    <= op.image_track;
		in_ch.image_offset   <= op.image_offset;
		do @(posedge clk); while (!in_ch.ready);
		status_q.push_back(drive_step(op));
		if (tx_burst > 0) tx_burst--;
	endtask

	// Send an item; load the byte under the head first if a shift read would fetch
	// a track entry that was never written
	task automatic send_op(input bus_op_t op);
		logic [IOFS_W-1:0] ofs;
		int unsigned       idx;
		if (op.command == CMD_SHIFT_READ && motor && shift_bits == 0
				&& head_ht[HT_W-1:1] < TRACK_COUNT) begin
			ofs = (head_ofs >= track_len_eff()) ? '0 : head_ofs;
			idx = head_ht[HT_W-1:1] * TRACK_BYTES + ofs;
			if (!disk_known[idx])
				push_item(mk_op(CMD_LOAD_BYTE, SW_IDLE, 8'($urandom), head_ht[HT_W-1:1], ofs));
		end
		push_item(op);
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (IDLE_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TRACK_LENGTH) len_cfg = data;
		else protect_cfg = data[0];
	endtask

	// Phase stepping toward and away from the head, clamps at both ends
	task automatic test_head_stepping();
		send_op(mk_op(CMD_SWITCH_READ, SW_IDLE, 8'h00, 0, 0));
		send_op(mk_op(CMD_SWITCH_READ, SW_PHASE_ON[1], 8'hFF, 0, 0));
		send_op(mk_op(CMD_SWITCH_READ, SW_PHASE_ON[2], 8'h00, 0, 0));
		send_op(mk_op(CMD_SWITCH_READ, SW_PHASE_ON[0], 8'h00, 0, 0));
		send_op(mk_op(CMD_SWITCH_READ, SW_PHASE_ON[1], 8'h00, 0, 0));
		send_op(mk_op(CMD_SWITCH_READ, SW_PHASE_ON[0], 8'h00, 0, 0));
		send_op(mk_op(CMD_SWITCH_READ, SW_PHASE_ON[3], 8'h00, 0, 0));
		send_op(mk_op(CMD_SET_HALF_TRACK, SW_IDLE, 8'hFF, 0, 0));
		send_op(mk_op(CMD_SWITCH_READ, SW_PHASE_ON[1], 8'h00, 0, 0));
		send_op(mk_op(CMD_SET_HALF_TRACK, SW_IDLE, 8'h00, 0, 0));
	endtask

	// Write-protect sense through Q6H then Q7L, and with Q6 low
	task automatic test_protect_sense();
		wait_idle();
		write_reg(REG_WRITE_PROTECTED, {12'h000, 1'b1});
		send_op(mk_op(CMD_SWITCH_READ, SW_Q6H, 8'h00, 0, 0));
		send_op(mk_op(CMD_SWITCH_READ, SW_Q7L, 8'h00, 0, 0));
		send_op(mk_op(CMD_SWITCH_READ, SW_Q6L, 8'h00, 0, 0));
		send_op(mk_op(CMD_SWITCH_READ, SW_Q7L, 8'h00, 0, 0));
	endtask

	// Commit with the motor off and the disk protected, then latch through Q6H
	task automatic test_write_commit();
		send_op(mk_op(CMD_SWITCH_WRITE, SW_Q7H, 8'hA5, 0, 0));
		send_op(mk_op(CMD_SWITCH_READ, SW_Q6L, 8'h00, 0, 0));
		send_op(mk_op(CMD_SWITCH_WRITE, SW_Q6H, 8'h3C, 0, 0));
		send_op(mk_op(CMD_SWITCH_READ, SW_Q7L, 8'h00, 0, 0));
		send_op(mk_op(CMD_SWITCH_WRITE, SW_IDLE, 8'hFF, 0, 0));
		wait_idle();
		write_reg(REG_WRITE_PROTECTED, {12'hFFF, 1'b0});
	endtask

	// Shift reads with the motor off, on, and off again
	task automatic test_shift_read();
		send_op(mk_op(CMD_LOAD_BYTE, SW_IDLE, 8'hFF, 0, 2));
		send_op(mk_op(CMD_LOAD_BYTE, SW_IDLE, 8'h00, 0, 3));
		send_op(mk_op(CMD_SHIFT_READ, SW_IDLE, 8'h00, 0, 0));
		send_op(mk_op(CMD_MOTOR_SET, SW_IDLE, 8'hFF, 0, 0));
		repeat (4) send_op(mk_op(CMD_SHIFT_READ, SW_IDLE, 8'h00, 0, 0));
		send_op(mk_op(CMD_MOTOR_SET, SW_IDLE, 8'hFE, 0, 0));
		send_op(mk_op(CMD_SHIFT_READ, SW_IDLE, 8'h00, 0, 0));
	endtask

	// Out-of-range image loads, the far corner of the image, unused commands
	task automatic test_ignored_items();
		send_op(mk_op(CMD_LOAD_BYTE, SW_IDLE, 8'h5A, 6'h3F, 0));
		send_op(mk_op(CMD_LOAD_BYTE, SW_IDLE, 8'h5A, 34, 13'h1FFF));
		send_op(mk_op(CMD_LOAD_BYTE, SW_IDLE, 8'hC3, 34, 13'(TRACK_BYTES - 1)));
		send_op(mk_op(CMD_SPARE6, 4'hF, 8'hFF, 6'h3F, 13'h1FFF));
		send_op(mk_op(CMD_SPARE7, 4'hF, 8'hFF, 6'h3F, 13'h1FFF));
	endtask

	// Shrink the track under the head, then the zero and oversize lengths
	task automatic test_head_wrap();
		wait_idle();
		write_reg(REG_TRACK_LENGTH, 13'(TRACK_BYTES));
		send_op(mk_op(CMD_SWITCH_WRITE, SW_Q7H, 8'h96, 0, 0));
		send_op(mk_op(CMD_SWITCH_READ, SW_Q6L, 8'h00, 0, 0));
		send_op(mk_op(CMD_SWITCH_READ, SW_Q6L, 8'h00, 0, 0));
		wait_idle();
		write_reg(REG_TRACK_LENGTH, 13'd2);
		send_op(mk_op(CMD_MOTOR_SET, SW_IDLE, 8'h01, 0, 0));
		send_op(mk_op(CMD_SHIFT_READ, SW_IDLE, 8'h00, 0, 0));
		send_op(mk_op(CMD_SWITCH_READ, SW_Q7L, 8'h00, 0, 0));
		wait_idle();
		write_reg(REG_TRACK_LENGTH, 13'd0);
		repeat (3) send_op(mk_op(CMD_SHIFT_READ, SW_IDLE, 8'h00, 0, 0));
		wait_idle();
		write_reg(REG_TRACK_LENGTH, 13'h1FFF);
		send_op(mk_op(CMD_SHIFT_READ, SW_IDLE, 8'h00, 0, 0));
	endtask

	// Receiver holds off for a long stretch while items keep coming
	task automatic test_backpressure();
		wait_idle();
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		rx_hold_req = 1'b1;
		send_op(mk_op(CMD_MOTOR_SET, SW_IDLE, 8'h01, 0, 0));
		repeat (40)
			send_op(rand_op($urandom_range(0, 1) ? CMD_SHIFT_READ : CMD_SWITCH_READ));
	endtask

	// Random traffic in phases, each with its own register settings and pacing
	task automatic test_random_traffic();
		bus_op_t     op;
		int          counted;
		int          k;
		int          r;
		int          lim;
		int          base;
		bit          up;
		logic [12:0] len;
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			case (ph)
				0: len = 13'(TRACK_BYTES);
				1: len = 13'd1;
				2: len = 13'd0;
				3: len = 13'h1FFF;
				4: len = 13'($urandom_range(2, 16));
				5: len = 13'($urandom_range(17, 300));
				6: len = 13'($urandom_range(1, 8191));
				default: len = 13'($urandom_range(2, 64));
			endcase
			write_reg(REG_TRACK_LENGTH, len);
			write_reg(REG_WRITE_PROTECTED, {12'($urandom), 1'($urandom)});
			tx_gaps   = (ph % 3) != 0;
			rx_stalls = (ph % 2) == 1 || ph == 4;
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 30) begin
					// stream of shift reads with the motor running
					if (!motor) begin
						op = rand_op(CMD_MOTOR_SET);
						op.value[0] = 1'b1;
						send_op(op);
						counted++;
					end
					k = $urandom_range(2, 16);
					repeat (k) send_op(rand_op(CMD_SHIFT_READ));
					counted += k;
				end else if (r < 45) begin
					// preload bytes just ahead of the head
					lim  = track_len_eff();
					base = (head_ofs >= lim) ? 0 : int'(head_ofs);
					k = $urandom_range(1, 8);
					for (int j = 0; j < k; j++) begin
						op = rand_op(CMD_LOAD_BYTE);
						op.image_track  = head_ht[HT_W-1:1];
						op.image_offset = 13'((base + j) % lim);
						send_op(op);
					end
					counted += k;
				end else if (r < 60) begin
					// latch and commit bytes at the head
					k = $urandom_range(1, 4);
					repeat (k) begin
						op = rand_op(CMD_SWITCH_WRITE);
						op.switch_address = ($urandom_range(0, 3) == 0) ? SW_Q6H : SW_Q7H;
						send_op(op);
						op = rand_op(CMD_SWITCH_READ);
						op.switch_address = SW_Q6L;
						send_op(op);
					end
					counted += 2 * k;
					if ($urandom_range(0, 1)) begin
						op = rand_op(CMD_SWITCH_READ);
						op.switch_address = SW_Q7L;
						send_op(op);
						counted++;
					end
				end else if (r < 72) begin
					// seek by direct set or by stepping the phases
					if ($urandom_range(0, 9) == 0) begin
						op = rand_op(CMD_SET_HALF_TRACK);
						if ($urandom_range(0, 1)) op.value = 8'($urandom_range(0, LAST_HALF_TRACK));
						send_op(op);
						counted++;
					end else begin
						k  = $urandom_range(1, 6);
						up = 1'($urandom);
						repeat (k) begin
							op = rand_op(CMD_SWITCH_READ);
							op.switch_address = SW_PHASE_ON[2'(head_ht[1:0] + (up ? 2'd1 : 2'd3))];
							send_op(op);
						end
						counted += k;
					end
				end else if (r < 80) begin
					op = rand_op(CMD_SWITCH_READ);
					op.switch_address = SW_Q6H;
					send_op(op);
					op = rand_op(CMD_SWITCH_READ);
					op.switch_address = SW_Q7L;
					send_op(op);
					counted += 2;
				end else if (r < 86) begin
					send_op(rand_op(CMD_MOTOR_SET));
					counted++;
				end else begin
					// noise: any command, any field value
					send_op(rand_op(3'($urandom)));
				end
			end
		end
	endtask

	// Receiver pacing: optional long hold, then random stall runs or always ready
	initial begin : rx_pacing
		int stall;
		stall = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end
			if (!rx_stalls) begin
				out_ch.ready <= 1'b1;
			end else if (stall > 0) begin
				out_ch.ready <= 1'b0;
				stall--;
			end else if ($urandom_range(0, 99) < 30) begin
				out_ch.ready <= 1'b0;
				stall = $urandom_range(0, 7);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each result with the oldest predicted status
	always @(posedge clk) begin : check_results
		drive_status_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (status_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d with nothing pending: rd=%02h ht=%0d mod=%0b mot=%0b",
						results_seen, out_ch.read_data, out_ch.half_track,
						out_ch.modified, out_ch.motor_on);
			end else begin
				want = status_q.pop_front();
				if (out_ch.read_data !== want.read_data || out_ch.half_track !== want.half_track
						|| out_ch.modified !== want.modified
						|| out_ch.motor_on !== want.motor_on) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d mismatch: expected rd=%02h ht=%0d mod=%0b mot=%0b, %s",
							results_seen, want.read_data, want.half_track, want.modified,
							want.motor_on, $sformatf("got rd=%02h ht=%0d mod=%0b mot=%0b",
							out_ch.read_data, out_ch.half_track, out_ch.modified,
							out_ch.motor_on));
				end
			end
		end
	end

	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("simulation failed");
		$finish;
	end

	initial begin : run_tests
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		in_ch.valid          = 1'b0;
		in_ch.command        = '0;
		in_ch.switch_address = '0;
		in_ch.value          = '0;
		in_ch.image_track    = '0;
		in_ch.image_offset   = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_head_stepping();
		test_protect_sense();
		test_write_commit();
		test_shift_read();
		test_ignored_items();
		test_head_wrap();
		test_backpressure();
		test_random_traffic();
		wait_idle();

		if (mismatches == 0 && status_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
